// ----- rtl/cewu_pkg.sv -----
// Shared constants and types for the covariance error-ellipse unit.
// No dependencies; used by the CORDIC stage and the top level.
package cewu_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 36;
    localparam int ANGLE_W      = 18;
    localparam int TILT_W       = 15;
    localparam int GAIN_W       = 16;

    localparam logic [TILT_W-1:0] TILT_MAX   = 15'd12868;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;

    // atan(2^-i) scaled by 65536
    localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        18'sd51472, 18'sd30386, 18'sd16055, 18'sd8150,
        18'sd4091,  18'sd2047,  18'sd1024,  18'sd512,
        18'sd256,   18'sd128,   18'sd64,    18'sd32,
        18'sd16,    18'sd8,     18'sd4,     18'sd2
    };

    typedef logic signed [TILT_W-1:0]  t_tilt;
    typedef logic signed [ANGLE_W-1:0] t_angle;

endpackage

// ----- rtl/cewu_isqrt_pipe.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries a valid bit and a sideband word alongside; no package dependency.
module cewu_isqrt_pipe #(
    parameter int NW = 64,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_radicand,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [NW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);

    localparam int QW = NW / 2;
    localparam int RW = QW + 2;

    logic          r_v    [QW];
    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_root [QW];
    logic [NW-1:0] r_rad  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [RW-1:0] rem_in;
        logic [QW-1:0] root_in;
        logic [NW-1:0] rad_in;
        logic [SW-1:0] side_in;
        logic [RW+1:0] wide;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_radicand;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        assign wide  = {rem_in, rad_in[NW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = wide - trial;
        assign ge    = (wide >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[RW-1:0] : wide[RW-1:0];
                r_root[k] <= {root_in[QW-2:0], ge};
                r_rad[k]  <= {rad_in[NW-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_root  = r_root[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ----- rtl/cewu_cordic_pipe.sv -----
// Pipelined CORDIC vectoring, one micro-rotation per register stage.
// Depends on cewu_pkg for the arctangent table and widths.
module cewu_cordic_pipe #(
    parameter int SW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_x,
    input  logic [31:0]           i_y,
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output cewu_pkg::t_angle      o_angle,
    output logic [SW-1:0]         o_side
);

    localparam int N = cewu_pkg::CORDIC_STEPS;
    localparam int W = cewu_pkg::CORDIC_W;

    logic                r_v    [N];
    logic signed [W-1:0] r_x    [N];
    logic signed [W-1:0] r_y    [N];
    cewu_pkg::t_angle    r_z    [N];
    logic [SW-1:0]       r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                v_in;
        logic signed [W-1:0] x_in;
        logic signed [W-1:0] y_in;
        cewu_pkg::t_angle    z_in;
        logic [SW-1:0]       side_in;
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = {4'b0000, i_x};
            assign y_in    = {3'b000, i_y, 1'b0};
            assign z_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign x_in    = r_x[k-1];
            assign y_in    = r_y[k-1];
            assign z_in    = r_z[k-1];
            assign side_in = r_side[k-1];
        end

        assign xs = x_in >>> k;
        assign ys = y_in >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!y_in[W-1]) begin
                    r_x[k] <= x_in + ys;
                    r_y[k] <= y_in - xs;
                    r_z[k] <= z_in + cewu_pkg::ATAN_TAB[k];
                end else begin
                    r_x[k] <= x_in - ys;
                    r_y[k] <= y_in + xs;
                    r_z[k] <= z_in - cewu_pkg::ATAN_TAB[k];
                end
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_angle = r_z[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- rtl/covariance_error_ellipse_unit.sv -----
// Error ellipse of a 2x2 covariance: half axes and tilt, fully pipelined.
// Depends on cewu_pkg, cewu_cordic_pipe and cewu_isqrt_pipe.
//
// One item enters per clock and passes through 80 register stages. The stages
// are the difference and square registers of stages a, b and c, 16 CORDIC
// stages, the tilt register, 32 stages for the eigenvalue root, the eigenvalue
// register, 25 stages for the axis roots, the gain product register and the
// output register. While a result waits on the output with stall high, every
// stage holds and the input channel stalls; otherwise a transfer is taken
// every cycle. axis_gain is unsigned Q8.8 and resets to 10.0.
module covariance_error_ellipse_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_var_x,
    input  logic [31:0]         i_var_y,
    input  logic signed [31:0]  i_cov_xy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [31:0]         o_first_axis,
    output logic [31:0]         o_second_axis,
    output logic signed [14:0]  o_tilt,
    output logic                o_clamped
);

    typedef struct packed {
        logic [62:0] m;
        logic        clamp;
        logic [32:0] s;
        logic        dneg;
        logic        cneg;
        logic        adz;
        logic        acz;
    } t_csd;

    typedef struct packed {
        cewu_pkg::t_tilt tilt;
        logic            clamp;
        logic [32:0]     s;
        logic            dneg;
    } t_rsd;

    typedef struct packed {
        cewu_pkg::t_tilt tilt;
        logic            clamp;
    } t_asd;

    logic        w_en;
    logic [15:0] r_gain;

    // stage a
    logic        w_cneg, w_dneg;
    logic [31:0] w_ac, w_ad;
    logic        r_a_v, r_a_dneg, r_a_cneg;
    logic [31:0] r_a_ad, r_a_ac;
    logic [32:0] r_a_s;
    logic [63:0] r_a_xy;
    // stage b
    logic        r_b_v, r_b_dneg, r_b_cneg;
    logic [31:0] r_b_ad, r_b_ac;
    logic [32:0] r_b_s;
    logic [63:0] r_b_xy, r_b_ad2, r_b_c2;
    // stage c
    logic        r_c_v;
    logic [31:0] r_c_ad, r_c_ac;
    t_csd        r_c_side;
    // cordic out / stage d
    logic             w_k_v;
    cewu_pkg::t_angle w_k_z;
    t_csd             w_k_side;
    logic [17:0]      w_zc, w_mw;
    logic [14:0]      w_mag;
    cewu_pkg::t_tilt  w_tilt;
    logic             r_d_v;
    logic [62:0]      r_d_m;
    t_rsd             r_d_side;
    // root out / stage e
    logic        w_r_v;
    logic [31:0] w_r;
    t_rsd        w_r_side;
    logic [32:0] w_2r;
    logic        r_e_v;
    logic [33:0] r_e_t1;
    logic [32:0] r_e_t2;
    t_asd        r_e_side;
    logic        r_e_dneg;
    // axis roots / stage f
    logic        w_qa_v, w_qb_v;
    logic [24:0] w_qa, w_qb;
    t_asd        w_qa_side;
    logic        w_qb_dneg;
    logic        r_f_v;
    logic [40:0] r_f_p1, r_f_p2;
    t_asd        r_f_side;
    logic        r_f_dneg;
    // output
    logic [41:0] w_rnd1, w_rnd2;
    logic [31:0] w_ax1, w_ax2;

    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= cewu_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // stage a: magnitudes, sum, x*y
    assign w_cneg = i_cov_xy[31];
    assign w_ac   = w_cneg ? (~unsigned'(i_cov_xy) + 32'd1) : unsigned'(i_cov_xy);
    assign w_dneg = i_var_x < i_var_y;
    assign w_ad   = w_dneg ? (i_var_y - i_var_x) : (i_var_x - i_var_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= w_k_v;
            r_e_v <= w_r_v;
            r_f_v <= w_qa_v & w_qb_v;
            o_valid <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ad   <= w_ad;
            r_a_ac   <= w_ac;
            r_a_dneg <= w_dneg;
            r_a_cneg <= w_cneg;
            r_a_s    <= {1'b0, i_var_x} + {1'b0, i_var_y};
            r_a_xy   <= 64'(i_var_x) * 64'(i_var_y);

            r_b_ad2  <= 64'(r_a_ad) * 64'(r_a_ad);
            r_b_c2   <= 64'(r_a_ac) * 64'(r_a_ac);
            r_b_xy   <= r_a_xy;
            r_b_ad   <= r_a_ad;
            r_b_ac   <= r_a_ac;
            r_b_s    <= r_a_s;
            r_b_dneg <= r_a_dneg;
            r_b_cneg <= r_a_cneg;

            r_c_side.m     <= {1'b0, r_b_ad2[63:2]} + r_b_c2[62:0];
            r_c_side.clamp <= r_b_xy < r_b_c2;
            r_c_side.s     <= r_b_s;
            r_c_side.dneg  <= r_b_dneg;
            r_c_side.cneg  <= r_b_cneg;
            r_c_side.adz   <= (r_b_ad == '0);
            r_c_side.acz   <= (r_b_ac == '0);
            r_c_ad         <= r_b_ad;
            r_c_ac         <= r_b_ac;
        end
    end

    cewu_cordic_pipe #(
        .SW ($bits(t_csd))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_x     (r_c_ad),
        .i_y     (r_c_ac),
        .i_side  (r_c_side),
        .o_valid (w_k_v),
        .o_angle (w_k_z),
        .o_side  (w_k_side)
    );

    // stage d: angle to tilt
    assign w_zc  = w_k_z[17] ? '0 : unsigned'(w_k_z);
    assign w_mw  = (w_zc + 18'd4) >> 3;
    assign w_mag = (w_mw > 18'(cewu_pkg::TILT_MAX)) ? cewu_pkg::TILT_MAX : w_mw[14:0];

    always_comb begin
        if (w_k_side.adz) begin
            if (w_k_side.acz) begin
                w_tilt = '0;
            end else if (w_k_side.cneg) begin
                w_tilt = -signed'(cewu_pkg::TILT_MAX);
            end else begin
                w_tilt = signed'(cewu_pkg::TILT_MAX);
            end
        end else if (w_k_side.acz) begin
            w_tilt = '0;
        end else if (w_k_side.cneg != w_k_side.dneg) begin
            w_tilt = -signed'(w_mag);
        end else begin
            w_tilt = signed'(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_m          <= w_k_side.m;
            r_d_side.tilt  <= w_tilt;
            r_d_side.clamp <= w_k_side.clamp;
            r_d_side.s     <= w_k_side.s;
            r_d_side.dneg  <= w_k_side.dneg;
        end
    end

    cewu_isqrt_pipe #(
        .NW (64),
        .SW ($bits(t_rsd))
    ) u_root_m (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_d_v),
        .i_radicand ({1'b0, r_d_m}),
        .i_side     (r_d_side),
        .o_valid    (w_r_v),
        .o_root     (w_r),
        .o_side     (w_r_side)
    );

    // stage e: twice the eigenvalues
    assign w_2r = {w_r, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_t1 <= {1'b0, w_r_side.s} + {1'b0, w_2r};
            if (w_r_side.clamp || (w_2r > w_r_side.s)) begin
                r_e_t2 <= '0;
            end else begin
                r_e_t2 <= w_r_side.s - w_2r;
            end
            r_e_side.tilt  <= w_r_side.tilt;
            r_e_side.clamp <= w_r_side.clamp;
            r_e_dneg       <= w_r_side.dneg;
        end
    end

    cewu_isqrt_pipe #(
        .NW (50),
        .SW ($bits(t_asd))
    ) u_root_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_e_v),
        .i_radicand ({1'b0, r_e_t1, 15'd0}),
        .i_side     (r_e_side),
        .o_valid    (w_qa_v),
        .o_root     (w_qa),
        .o_side     (w_qa_side)
    );

    cewu_isqrt_pipe #(
        .NW (50),
        .SW (1)
    ) u_root_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_e_v),
        .i_radicand ({2'b00, r_e_t2, 15'd0}),
        .i_side     (r_e_dneg),
        .o_valid    (w_qb_v),
        .o_root     (w_qb),
        .o_side     (w_qb_dneg)
    );

    // stage f: gain
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_p1   <= 41'(w_qa) * 41'(r_gain);
            r_f_p2   <= 41'(w_qb) * 41'(r_gain);
            r_f_side <= w_qa_side;
            r_f_dneg <= w_qb_dneg;
        end
    end

    // output: round, saturate, swap
    assign w_rnd1 = {1'b0, r_f_p1} + 42'd128;
    assign w_rnd2 = {1'b0, r_f_p2} + 42'd128;
    assign w_ax1  = (|w_rnd1[41:40]) ? '1 : w_rnd1[39:8];
    assign w_ax2  = (|w_rnd2[41:40]) ? '1 : w_rnd2[39:8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_first_axis  <= r_f_dneg ? w_ax2 : w_ax1;
            o_second_axis <= r_f_dneg ? w_ax1 : w_ax2;
            o_tilt        <= r_f_side.tilt;
            o_clamped     <= r_f_side.clamp;
        end
    end

`ifndef ASSERT_OFF
    a_clamp_zero_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamped |-> (o_first_axis == '0) || (o_second_axis == '0))
        else $error("clamped result without a zero axis");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tilt <= 15'sd12868) && (o_tilt >= -15'sd12868))
        else $error("tilt out of range");

    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to held output");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_d_v) && $stable(r_f_v))
        else $error("pipeline moved during stall");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qa_v == w_qb_v)
        else $error("axis root lanes out of step");
`endif

endmodule
